[sv/hti_pkg.sv]
`timescale 1ns / 1ps

package hti_pkg;

  // command codes carried by an input item
  typedef enum logic [1:0] {
    CmdPrefix  = 2'd0,
    CmdDrift   = 2'd1,
    CmdStart   = 2'd2,
    CmdAdvance = 2'd3
  } cmd_e;

  localparam int unsigned IdxW        = 10;
  localparam int unsigned CountW      = 11;
  localparam int unsigned PrefixW     = 64;
  localparam int unsigned OffW        = 62;
  localparam int unsigned DriftW      = 8;
  localparam int unsigned DriftSlotW  = 5;
  localparam int unsigned DriftDepth  = 32;
  localparam int unsigned CntW        = $clog2(OffW);
  localparam int unsigned CountReset  = 1024;

endpackage

[sv/hash_table_index_walker.sv]
`timescale 1ns / 1ps

// Hash table index walker. Holds a table of 64-bit hash prefixes in a
// synchronous memory of TABLE_DEPTH entries, a 32-entry drift byte memory and
// a current index. Each input item gives exactly one result item. Load items
// (write prefix, write drift byte, set start index) take effect at acceptance
// and their result is ready in the next cycle. An advance reads the current
// entry's prefix and drift byte through a registered read, then, for a
// jump, reduces the 62-bit offset modulo the span with a bit-serial restoring
// remainder unit, one dividend bit per cycle. A jumping advance passes
// through the read, remainder and final states; a plain step or an advance
// at the last entry skips the remainder state. One item is in flight at a
// time; a new item is taken at the earliest in the cycle in which the
// waiting result leaves the output register. The entry count
// register (cfg channel) may only be written while the block is idle;
// cfg_ready_o is always high.
// Prefix and drift entries hold nothing meaningful until written, and no
// clearing pass is made after reset.

module hash_table_index_walker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hti_pkg::CountW-1:0]          cfg_wdata_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [hti_pkg::IdxW-1:0]            entry_index_i,
  input  logic [hti_pkg::PrefixW-1:0]         hash_prefix_i,
  input  logic [hti_pkg::DriftSlotW-1:0]      drift_slot_i,
  input  logic [hti_pkg::DriftW-1:0]          drift_value_i,
  input  logic [hti_pkg::IdxW-1:0]            start_index_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hti_pkg::IdxW-1:0]            from_index_o,
  output logic [hti_pkg::IdxW-1:0]            to_index_o,
  output logic                                jump_flag_o,
  output logic                                dir_flag_o,
  output logic [hti_pkg::DriftW-1:0]          drift_used_o,
  output logic [hti_pkg::OffW-1:0]            offset_value_o,
  output logic                                epoch_end_o
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CountW = hti_pkg::CountW;
  localparam int unsigned OffW   = hti_pkg::OffW;
  localparam int unsigned IdxW   = hti_pkg::IdxW;

  // last index at reset, from the reset entry count clamped to the table
  localparam logic [CountW-1:0] LastReset = CountW'((TABLE_DEPTH < hti_pkg::CountReset) ?
                                                    TABLE_DEPTH - 1 : hti_pkg::CountReset - 1);
  // largest last index the table allows (only chosen when it fits the register)
  localparam logic [CountW-1:0] LastMax = CountW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StDiv  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  // control state
  state_e                 state_q, state_d;
  logic [CountW-1:0]      pos_q, pos_d;
  logic [CountW-1:0]      last_q;
  logic                   out_valid_q, out_valid_d;
  logic [hti_pkg::CntW-1:0] cnt_q, cnt_d;

  // memories
  logic [hti_pkg::PrefixW-1:0] prefix_mem [TABLE_DEPTH];
  logic [hti_pkg::DriftW-1:0]  drift_mem  [hti_pkg::DriftDepth];
  logic [hti_pkg::PrefixW-1:0] prefix_rd_q;
  logic [hti_pkg::DriftW-1:0]  drift_rd_q;

  // working registers of one advance
  logic [CountW-1:0]      cur_q;
  logic [CountW-1:0]      divisor_q;
  logic [CountW-1:0]      rem_q;
  logic [OffW-1:0]        div_q;
  logic [CountW-1:0]      next_q;
  logic                   use_rem_q;
  logic                   jump_q, dir_q, eend_q;
  logic [hti_pkg::DriftW-1:0] drift_q;
  logic [OffW-1:0]        offv_q;

  // output register
  logic [IdxW-1:0]        out_from_q, out_to_q;
  logic                   out_jump_q, out_dir_q, out_eend_q;
  logic [hti_pkg::DriftW-1:0] out_drift_q;
  logic [OffW-1:0]        out_offv_q;

  // handshake and decode
  logic                   out_free;
  logic                   in_acc;
  logic                   load_acc;
  logic                   adv_acc;
  logic                   prefix_we;
  logic                   fin_fire;
  hti_pkg::cmd_e          cmd;

  logic [CountW-1:0]      cur_sat;
  logic [CountW-1:0]      start_ext;
  logic [CountW-1:0]      start_sat;
  logic [CountW-1:0]      load_to;

  // read stage decode
  logic [OffW-1:0]        offv_rd;
  logic                   rd_at_last;
  logic                   rd_use_rem;

  // remainder step
  logic [CountW:0]        trial;
  logic [CountW:0]        trial_sub;
  logic [CountW-1:0]      rem_nx;

  // final index
  logic [CountW-1:0]      step;
  logic [CountW-1:0]      jump_next;
  logic [CountW-1:0]      fin_next;

  assign cfg_ready_o = 1'b1;

  assign cmd       = hti_pkg::cmd_e'(cmd_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_acc    = in_valid_i && in_ready_o;
  assign adv_acc   = in_acc && (cmd == hti_pkg::CmdAdvance);
  assign load_acc  = in_acc && (cmd != hti_pkg::CmdAdvance);
  assign prefix_we = in_acc && (cmd == hti_pkg::CmdPrefix) &&
                     (32'(entry_index_i) < TABLE_DEPTH);
  assign fin_fire  = (state_q == StFin) && out_free;

  // an index left beyond a shrunk entry count is pulled back to the last entry
  assign cur_sat   = (pos_q > last_q) ? last_q : pos_q;
  assign start_ext = CountW'(start_index_i);
  assign start_sat = (start_ext > last_q) ? last_q : start_ext;
  assign load_to   = (cmd == hti_pkg::CmdStart) ? start_sat : pos_q;

  assign offv_rd    = prefix_rd_q[hti_pkg::PrefixW-1:2] ^ OffW'(drift_rd_q);
  assign rd_at_last = (cur_q >= last_q);
  // backward jump from index zero falls back to a plain step
  assign rd_use_rem = !rd_at_last && prefix_rd_q[0] &&
                      (!prefix_rd_q[1] || (cur_q != '0));

  // restoring remainder, one dividend bit a cycle
  assign trial     = {rem_q, div_q[OffW-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign rem_nx    = (trial >= {1'b0, divisor_q}) ? trial_sub[CountW-1:0] : trial[CountW-1:0];

  // zero remainder still moves by one
  assign step      = (rem_q == '0) ? CountW'(1) : rem_q;
  assign jump_next = dir_q ? (cur_q - step) : (cur_q + step);
  assign fin_next  = use_rem_q ? jump_next : next_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (load_acc) begin
          pos_d       = load_to;
          out_valid_d = 1'b1;
        end else if (adv_acc) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cnt_d   = '0;
        state_d = rd_use_rem ? StDiv : StFin;
      end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == hti_pkg::CntW'(OffW - 1)) begin
          cnt_d   = '0;
          state_d = StFin;
        end
      end
      StFin: begin
        if (fin_fire) begin
          pos_d       = fin_next;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      last_q      <= LastReset;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        // entry count clamped to two and to the table depth
        if (cfg_wdata_i < CountW'(2)) begin
          last_q <= CountW'(1);
        end else if (32'(cfg_wdata_i) > TABLE_DEPTH) begin
          last_q <= LastMax;
        end else begin
          last_q <= cfg_wdata_i - 1'b1;
        end
      end
    end
  end

  // prefix memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (prefix_we) begin
      prefix_mem[AW'(entry_index_i)] <= hash_prefix_i;
    end
    if (adv_acc) begin
      prefix_rd_q <= prefix_mem[AW'(cur_sat)];
    end
  end

  // drift memory, written by slot and read at the current index mod 32
  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd == hti_pkg::CmdDrift)) begin
      drift_mem[drift_slot_i] <= drift_value_i;
    end
    if (adv_acc) begin
      drift_rd_q <= drift_mem[cur_sat[hti_pkg::DriftSlotW-1:0]];
    end
  end

  // advance datapath
  always_ff @(posedge clk_i) begin
    if (adv_acc) begin
      cur_q <= cur_sat;
    end
    if (state_q == StRead) begin
      jump_q    <= prefix_rd_q[0];
      dir_q     <= prefix_rd_q[1];
      drift_q   <= drift_rd_q;
      offv_q    <= offv_rd;
      div_q     <= offv_rd;
      rem_q     <= '0;
      divisor_q <= prefix_rd_q[1] ? cur_q : (last_q - cur_q);
      eend_q    <= rd_at_last;
      use_rem_q <= rd_use_rem;
      next_q    <= rd_at_last ? cur_q : (cur_q + 1'b1);
    end
    if (state_q == StDiv) begin
      rem_q <= rem_nx;
      div_q <= {div_q[OffW-2:0], 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      out_from_q  <= '0;
      out_to_q    <= load_to[IdxW-1:0];
      out_jump_q  <= 1'b0;
      out_dir_q   <= 1'b0;
      out_drift_q <= '0;
      out_offv_q  <= '0;
      out_eend_q  <= 1'b0;
    end else if (fin_fire) begin
      out_from_q  <= cur_q[IdxW-1:0];
      out_to_q    <= fin_next[IdxW-1:0];
      out_jump_q  <= jump_q;
      out_dir_q   <= dir_q;
      out_drift_q <= drift_q;
      out_offv_q  <= offv_q;
      out_eend_q  <= eend_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign from_index_o   = out_from_q;
  assign to_index_o     = out_to_q;
  assign jump_flag_o    = out_jump_q;
  assign dir_flag_o     = out_dir_q;
  assign drift_used_o   = out_drift_q;
  assign offset_value_o = out_offv_q;
  assign epoch_end_o    = out_eend_q;

endmodule

[sv/hti_checker.sv]
`timescale 1ns / 1ps

module hti_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [hti_pkg::CountW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [hti_pkg::IdxW-1:0]       entry_index_i,
  input  logic [hti_pkg::PrefixW-1:0]    hash_prefix_i,
  input  logic [hti_pkg::DriftSlotW-1:0] drift_slot_i,
  input  logic [hti_pkg::DriftW-1:0]     drift_value_i,
  input  logic [hti_pkg::IdxW-1:0]       start_index_i,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [hti_pkg::IdxW-1:0]       from_index_o,
  input  logic [hti_pkg::IdxW-1:0]       to_index_o,
  input  logic                           jump_flag_o,
  input  logic                           dir_flag_o,
  input  logic [hti_pkg::DriftW-1:0]     drift_used_o,
  input  logic [hti_pkg::OffW-1:0]       offset_value_o,
  input  logic                           epoch_end_o
);

  // a waiting result item holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(to_index_o) &&
      $stable(from_index_o) && $stable(offset_value_o) && $stable(epoch_end_o))
    else $error("result item changed while stalled");

  // epoch end never moves the walker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && epoch_end_o |-> (from_index_o == to_index_o))
    else $error("epoch end with a move");

  // an advance keeps the input closed while it reads the tables
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == hti_pkg::CmdAdvance) |=> !in_ready_o)
    else $error("input open during an advance");

  // a load item's result follows at once and carries none of the advance fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i != hti_pkg::CmdAdvance) |=>
      out_valid_o && !epoch_end_o && !jump_flag_o && !dir_flag_o &&
      (drift_used_o == '0) && (from_index_o == '0))
    else $error("load item result not clean");

endmodule

bind hash_table_index_walker hti_checker u_hti_checker (.*);

[dv/hash_table_index_walker_checker.sv]
`timescale 1ns / 1ps

module hash_table_index_walker_checker
  import hti_pkg::*;
#(
  parameter int unsigned TableDepth = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CountW-1:0]     cfg_wdata_i,

  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            cmd_i,
  input  logic [IdxW-1:0]       entry_index_i,
  input  logic [PrefixW-1:0]    hash_prefix_i,
  input  logic [DriftSlotW-1:0] drift_slot_i,
  input  logic [DriftW-1:0]     drift_value_i,
  input  logic [IdxW-1:0]       start_index_i,

  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [IdxW-1:0]       from_index_i,
  input  logic [IdxW-1:0]       to_index_i,
  input  logic                  jump_flag_i,
  input  logic                  dir_flag_i,
  input  logic [DriftW-1:0]     drift_used_i,
  input  logic [OffW-1:0]       offset_value_i,
  input  logic                  epoch_end_i,

  output int unsigned           mismatch_count_o,
  output int unsigned           results_pending_o
);

  typedef struct packed {
    logic [IdxW-1:0]   from_idx;
    logic [IdxW-1:0]   to_idx;
    logic              jump;
    logic              dir;
    logic [DriftW-1:0] drift;
    logic [OffW-1:0]   offset;
    logic              eend;
  } walk_t;

  // own copy of the walker state
  bit [PrefixW-1:0] prefix_mem [TableDepth];
  bit [DriftW-1:0]  drift_mem  [DriftDepth];
  int unsigned      walk_pos   = 0;
  int unsigned      span_count = CountReset;

  walk_t       expected_walk_q [$];
  int unsigned bad_total = 0;
  int unsigned pending_n = 0;

  assign mismatch_count_o  = bad_total;
  assign results_pending_o = pending_n;

  function automatic walk_t walk_step(cmd_e c, logic [IdxW-1:0] ent, logic [PrefixW-1:0] pfx,
                                      logic [DriftSlotW-1:0] slot, logic [DriftW-1:0] dval,
                                      logic [IdxW-1:0] start);
    walk_t            r;
    int unsigned      n, last, cur, nxt, span;
    bit [PrefixW-1:0] p;
    bit [63:0]        rem;
    r = '0;
    n = span_count;
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    last = n - 1;
    case (c)
      CmdPrefix: if (ent < TableDepth) prefix_mem[ent] = pfx;
      CmdDrift:  drift_mem[slot] = dval;
      CmdStart:  walk_pos = (32'(start) > last) ? last : 32'(start);
      default: begin
        // a shrunk entry count pulls the index back to the last entry first
        cur = (walk_pos > last) ? last : walk_pos;
        p = prefix_mem[cur];
        r.from_idx = IdxW'(cur);
        r.jump = p[0];
        r.dir = p[1];
        r.drift = drift_mem[cur % DriftDepth];
        r.offset = p[PrefixW-1:2] ^ OffW'(r.drift);
        if (cur >= last) begin
          nxt = cur;
          r.eend = 1'b1;
        end else if (!p[0]) begin
          nxt = cur + 1;
        end else if (!p[1]) begin
          span = last - cur;
          rem = {2'b00, r.offset} % 64'(span);
          nxt = cur + ((rem == 0) ? 1 : 32'(rem));
        end else if (cur > 0) begin
          rem = {2'b00, r.offset} % 64'(cur);
          nxt = cur - ((rem == 0) ? 1 : 32'(rem));
        end else begin
          nxt = cur + 1;
        end
        walk_pos = nxt;
      end
    endcase
    r.to_idx = IdxW'(walk_pos);
    return r;
  endfunction

  function automatic int unsigned compare_walk(walk_t w, walk_t g);
    int unsigned n;
    n = 0;
    if (g.from_idx !== w.from_idx) begin
      $error("from_index: expected %0d, got %0d", w.from_idx, g.from_idx);
      n++;
    end
    if (g.to_idx !== w.to_idx) begin
      $error("to_index: expected %0d, got %0d", w.to_idx, g.to_idx);
      n++;
    end
    if (g.jump !== w.jump) begin
      $error("jump_flag: expected %0d, got %0d", w.jump, g.jump);
      n++;
    end
    if (g.dir !== w.dir) begin
      $error("dir_flag: expected %0d, got %0d", w.dir, g.dir);
      n++;
    end
    if (g.drift !== w.drift) begin
      $error("drift_used: expected %0h, got %0h", w.drift, g.drift);
      n++;
    end
    if (g.offset !== w.offset) begin
      $error("offset_value: expected %0h, got %0h", w.offset, g.offset);
      n++;
    end
    if (g.eend !== w.eend) begin
      $error("epoch_end: expected %0d, got %0d", w.eend, g.eend);
      n++;
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    walk_t       got;
    int unsigned n_bad;
    n_bad = 0;
    if (!rst_ni) begin
      expected_walk_q.delete();
      walk_pos = 0;
      span_count = CountReset;
      pending_n <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) span_count = 32'(cfg_wdata_i);
      if (out_valid_i && out_ready_i) begin
        got.from_idx = from_index_i;
        got.to_idx = to_index_i;
        got.jump = jump_flag_i;
        got.dir = dir_flag_i;
        got.drift = drift_used_i;
        got.offset = offset_value_i;
        got.eend = epoch_end_i;
        if (expected_walk_q.size() == 0) begin
          $error("result item with no item outstanding");
          n_bad = 1;
        end else begin
          n_bad = compare_walk(expected_walk_q.pop_front(), got);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_walk_q.push_back(walk_step(cmd_e'(cmd_i), entry_index_i, hash_prefix_i,
                                            drift_slot_i, drift_value_i, start_index_i));
      pending_n <= expected_walk_q.size();
      bad_total <= bad_total + n_bad;
    end
  end

endmodule

[dv/tb_hash_table_index_walker.sv]
`timescale 1ns / 1ps

module tb_hash_table_index_walker;
  import hti_pkg::*;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CountW-1:0]     cfg_wdata_i = '0;

  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            cmd_i = '0;
  logic [IdxW-1:0]       entry_index_i = '0;
  logic [PrefixW-1:0]    hash_prefix_i = '0;
  logic [DriftSlotW-1:0] drift_slot_i = '0;
  logic [DriftW-1:0]     drift_value_i = '0;
  logic [IdxW-1:0]       start_index_i = '0;

  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IdxW-1:0]       from_index_o;
  logic [IdxW-1:0]       to_index_o;
  logic                  jump_flag_o;
  logic                  dir_flag_o;
  logic [DriftW-1:0]     drift_used_o;
  logic [OffW-1:0]       offset_value_o;
  logic                  epoch_end_o;

  int unsigned mismatch_count;
  int unsigned results_pending;

  // stimulus bookkeeping: which prefix entries hold a value, and the last
  // index of the current entry count, so no advance ever reads an empty entry
  bit          prefix_written [TableDepth];
  int unsigned span_last = TableDepth - 1;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  bit          hold_req = 1'b0;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hash_table_index_walker #(
    .TABLE_DEPTH(TableDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .hash_prefix_i  (hash_prefix_i),
    .drift_slot_i   (drift_slot_i),
    .drift_value_i  (drift_value_i),
    .start_index_i  (start_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .from_index_o   (from_index_o),
    .to_index_o     (to_index_o),
    .jump_flag_o    (jump_flag_o),
    .dir_flag_o     (dir_flag_o),
    .drift_used_o   (drift_used_o),
    .offset_value_o (offset_value_o),
    .epoch_end_o    (epoch_end_o)
  );

  hash_table_index_walker_checker #(
    .TableDepth(TableDepth)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .cmd_i             (cmd_i),
    .entry_index_i     (entry_index_i),
    .hash_prefix_i     (hash_prefix_i),
    .drift_slot_i      (drift_slot_i),
    .drift_value_i     (drift_value_i),
    .start_index_i     (start_index_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .from_index_i      (from_index_o),
    .to_index_i        (to_index_o),
    .jump_flag_i       (jump_flag_o),
    .dir_flag_i        (dir_flag_o),
    .drift_used_i      (drift_used_o),
    .offset_value_i    (offset_value_o),
    .epoch_end_i       (epoch_end_o),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  // offer one item and wait for it to be taken; idx is the entry for a prefix
  // write, the slot for a drift write and the start index for a start, and
  // every field the command does not use carries random noise
  task automatic send_item(cmd_e c, logic [IdxW-1:0] idx, logic [PrefixW-1:0] pfx,
                           logic [DriftW-1:0] dval);
    int unsigned gap;
    // bursts of random length, separated by short or occasionally long gaps
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    entry_index_i <= (c == CmdPrefix) ? idx : IdxW'($urandom);
    hash_prefix_i <= (c == CmdPrefix) ? pfx : {$urandom, $urandom};
    drift_slot_i  <= (c == CmdDrift) ? idx[DriftSlotW-1:0] : DriftSlotW'($urandom);
    drift_value_i <= (c == CmdDrift) ? dval : DriftW'($urandom);
    start_index_i <= (c == CmdStart) ? idx : IdxW'($urandom);
    if (c == CmdPrefix) prefix_written[idx] = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait until every result item has come back; the pending
  // count is registered, hence the wait at a clock edge before the first look
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // new entry count, written while idle, then any entry now in reach that
  // was never written gets a random prefix
  task automatic new_span(int unsigned count);
    int unsigned n;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= CountW'(count);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n = (count < 2) ? 2 : (count > TableDepth) ? TableDepth : count;
    span_last = n - 1;
    for (int unsigned e = 0; e <= span_last; e++)
      if (!prefix_written[e]) send_item(CmdPrefix, IdxW'(e), {$urandom, $urandom}, '0);
  endtask

  // random walk: mostly advances, with rewrites of the tables and restarts
  // that keep the walker away from the last entry often enough
  task automatic walk_items(int unsigned n);
    int unsigned pick;
    logic [IdxW-1:0] idx;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_item(CmdAdvance, '0, '0, '0);
      end else if (pick < 70) begin
        idx = $urandom_range(1) ? IdxW'($urandom_range(span_last)) : IdxW'($urandom);
        send_item(CmdPrefix, idx, {$urandom, $urandom}, '0);
      end else if (pick < 80) begin
        send_item(CmdDrift, IdxW'($urandom), '0, DriftW'($urandom));
      end else begin
        idx = ($urandom_range(3) != 0) ? IdxW'($urandom_range(span_last)) : IdxW'($urandom);
        send_item(CmdStart, idx, '0, '0);
      end
    end
  endtask

  // receiver: segments of always ready, coin toss, mostly stalled and a fixed
  // on/off pattern, plus one long hold-off on request
  initial begin : sink
    int unsigned seg_left, sink_mode, hold_left, tick;
    seg_left = 0;
    sink_mode = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(200, 20);
          sink_mode = $urandom_range(3);
        end
        seg_left--;
        case (sink_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(1));
          2: out_ready_i <= ($urandom_range(4) == 0);
          default: out_ready_i <= ~tick[2];
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // drift table first, so every slot holds a value before any advance
    for (int unsigned s = 0; s < DriftDepth; s++)
      send_item(CmdDrift, IdxW'(s), '0, DriftW'($urandom));

    // directed walk over eight entries
    new_span(8);
    send_item(CmdPrefix, 10'd0, '1, '0);          // all ones: backward jump
    send_item(CmdPrefix, 10'd1023, '0, '0);       // top of the table, zero prefix
    send_item(CmdDrift, 10'd0, '0, 8'h00);
    send_item(CmdDrift, 10'd31, '0, 8'hFF);
    send_item(CmdStart, 10'd0, '0, '0);
    send_item(CmdAdvance, '0, '0, '0);            // backward jump at index zero steps forward
    send_item(CmdStart, 10'd1023, '0, '0);        // saturates to the last entry
    send_item(CmdAdvance, '0, '0, '0);            // epoch end, no move
    send_item(CmdPrefix, 10'd3, 64'h1, '0);
    send_item(CmdStart, 10'd3, '0, '0);
    send_item(CmdAdvance, '0, '0, '0);            // forward jump
    send_item(CmdPrefix, 10'd5, {$urandom, $urandom} | 64'h3, '0);
    send_item(CmdStart, 10'd5, '0, '0);
    send_item(CmdAdvance, '0, '0, '0);            // backward jump
    send_item(CmdPrefix, 10'd2, 64'h4, '0);
    send_item(CmdStart, 10'd2, '0, '0);
    send_item(CmdAdvance, '0, '0, '0);            // plain step, no jump
    send_item(CmdPrefix, 10'd6, 64'h1, '0);
    send_item(CmdStart, 10'd6, '0, '0);
    send_item(CmdAdvance, '0, '0, '0);            // span of one, offset reduces to zero
    send_item(CmdAdvance, '0, '0, '0);            // now at the last entry

    // shrink below the current index: the advance saturates, then ends the epoch
    new_span(2);
    send_item(CmdAdvance, '0, '0, '0);
    walk_items(30);

    // full table, with the receiver holding off while items keep coming
    new_span(1024);
    hold_req = 1'b1;
    walk_items(100);

    new_span(37);
    walk_items(50);
    new_span(1);                                  // acts as two
    walk_items(20);
    new_span(2047);                               // acts as the table depth
    walk_items(30);
    new_span(0);
    walk_items(15);
    new_span(300);
    walk_items(40);
    new_span(1023);
    walk_items(30);

    // drain every result item, then idle before the final check
    wait_idle();
    repeat (80) @(posedge clk_i);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
